// File: hdl/chss_pkg.sv
// Shared types and constants for the consistent-hash server select block.
// Holds widths, request and register codes and the sequencer state type.
// No dependencies.
`timescale 1ns / 1ps

package chss_pkg;

  localparam int MAX_POINTS_DEF = 4096;

  localparam int HASH_W  = 32;
  localparam int SRV_W   = 16;
  localparam int SLOT_W  = 12;
  localparam int PCNT_W  = 13;
  localparam int ENTRY_W = HASH_W + SRV_W;
  localparam int DIVCNT_W = $clog2(HASH_W);

  // request types
  localparam logic REQ_WRITE  = 1'b0;
  localparam logic REQ_LOOKUP = 1'b1;

  // distribution modes
  localparam logic MODE_RING = 1'b0;
  localparam logic MODE_MOD  = 1'b1;

  // status codes
  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_EMPTY = 1'b1;

  // register indexes (paddr[3:2])
  localparam logic [1:0] REG_MODE         = 2'd0;
  localparam logic [1:0] REG_SERVER_COUNT = 2'd1;
  localparam logic [1:0] REG_POINT_COUNT  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PROBE,
    ST_CMP,
    ST_FETCH,
    ST_DIV
  } chss_state_t;

endpackage

// File: hdl/chss_ring_mem.sv
// Ring point store: one write port, one read port, registered read data.
// Each entry packs {owner, value}. Uses chss_pkg for the entry width.
`timescale 1ns / 1ps

module chss_ring_mem #(
  parameter int DEPTH = chss_pkg::MAX_POINTS_DEF,
  parameter int AW    = 12
) (
  input  logic                         clk,
  input  logic                         we,
  input  logic [AW-1:0]                waddr,
  input  logic [chss_pkg::ENTRY_W-1:0] wdata,
  input  logic                         re,
  input  logic [AW-1:0]                raddr,
  output logic [chss_pkg::ENTRY_W-1:0] rdata
);

  logic [chss_pkg::ENTRY_W-1:0] mem [DEPTH];
  logic [chss_pkg::ENTRY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: hdl/chss_divider.sv
// Restoring radix-2 remainder unit: 32-bit dividend, 16-bit divisor.
// One quotient bit per cycle, done pulses after 32 steps. Uses chss_pkg.
`timescale 1ns / 1ps

module chss_divider (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [chss_pkg::HASH_W-1:0] dividend,
  input  logic [chss_pkg::SRV_W-1:0]  divisor,
  output logic                        done,
  output logic [chss_pkg::SRV_W-1:0]  remainder
);

  logic                          run_r;
  logic                          done_r;
  logic [chss_pkg::DIVCNT_W-1:0] cnt_r;
  logic [chss_pkg::HASH_W-1:0]   quo_r;
  logic [chss_pkg::SRV_W-1:0]    rem_r;
  logic [chss_pkg::SRV_W-1:0]    dsr_r;
  logic [chss_pkg::SRV_W:0]      shifted;
  logic [chss_pkg::SRV_W:0]      diff;
  logic [chss_pkg::SRV_W-1:0]    rem_nxt;

  always_comb begin
    shifted = {rem_r, quo_r[chss_pkg::HASH_W-1]};
    diff    = shifted - {1'b0, dsr_r};
    if (shifted >= {1'b0, dsr_r}) begin
      rem_nxt = diff[chss_pkg::SRV_W-1:0];
    end else begin
      rem_nxt = shifted[chss_pkg::SRV_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == '1) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= dividend;
      rem_r <= '0;
      dsr_r <= divisor;
    end else if (run_r) begin
      quo_r <= {quo_r[chss_pkg::HASH_W-2:0], 1'b0};
      rem_r <= rem_nxt;
    end
  end

  assign done      = done_r;
  assign remainder = rem_r;

endmodule

// File: hdl/consistent_hash_server_select_core.sv
// Consistent-hash server select core; uses chss_pkg, chss_ring_mem and chss_divider.
// A point write gives no result; an empty ring or zero server count is answered in
// the cycle after the request; a ring lookup repeats probe and compare on the point store,
// then a last probe and fetch; a modulo lookup waits on the 32-step remainder unit. Throughput:
// writes one per cycle while idle; after a lookup the next request is taken at the edge that
// ends its result strobe; the receiver cannot stall. Reset: sync, active low; store not cleared.
`timescale 1ns / 1ps

module consistent_hash_server_select_core #(
  parameter int MAX_POINTS = chss_pkg::MAX_POINTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // request channel
  input  logic                        start,
  output logic                        busy,
  input  logic                        in_req_type,
  input  logic [chss_pkg::SLOT_W-1:0] in_point_slot,
  input  logic [chss_pkg::HASH_W-1:0] in_point_hash,
  input  logic [chss_pkg::SRV_W-1:0]  in_point_owner,
  input  logic [chss_pkg::HASH_W-1:0] in_key_hash,
  // result channel
  output logic                        out_valid,
  output logic [chss_pkg::SRV_W-1:0]  out_server_index,
  output logic                        out_status,
  // configuration port
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [3:0]                  paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready
);

  // Store address width and search index width (index must reach the count).
  localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam logic [16:0] MAXP = 17'(MAX_POINTS);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic                        mode_r;
  logic [chss_pkg::SRV_W-1:0]  server_count_r;
  logic [chss_pkg::PCNT_W-1:0] point_count_r;
  logic                        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r         <= chss_pkg::MODE_RING;
      server_count_r <= 16'd1;
      point_count_r  <= '0;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        chss_pkg::REG_MODE:         mode_r         <= pwdata[0];
        chss_pkg::REG_SERVER_COUNT: server_count_r <= pwdata[chss_pkg::SRV_W-1:0];
        chss_pkg::REG_POINT_COUNT:  point_count_r  <= pwdata[chss_pkg::PCNT_W-1:0];
        default: ;  // drop writes to unmapped addresses
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      chss_pkg::REG_MODE:         prdata = 32'(mode_r);
      chss_pkg::REG_SERVER_COUNT: prdata = 32'(server_count_r);
      chss_pkg::REG_POINT_COUNT:  prdata = 32'(point_count_r);
      default:                    prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Request decode
  // ---------------------------------------------------------------------
  chss_pkg::chss_state_t state_r, state_nxt;

  logic                        accept;
  logic                        lookup;
  logic [chss_pkg::HASH_W-1:0] hash_eff;
  logic [16:0]                 pc_ext;
  logic [16:0]                 n_clamp;
  logic [CW-1:0]               n_eff;
  logic                        slot_ok;

  assign busy    = (state_r != chss_pkg::ST_IDLE);
  assign accept  = start & ~busy;
  assign lookup  = accept & (in_req_type == chss_pkg::REQ_LOOKUP);
  // A single server takes every key: treat the hash as zero.
  assign hash_eff = (server_count_r == 16'd1) ? '0 : in_key_hash;
  // Saturate the loaded point count at the store depth.
  assign pc_ext  = 17'(point_count_r);
  assign n_clamp = (pc_ext > MAXP) ? MAXP : pc_ext;
  assign n_eff   = CW'(n_clamp);
  assign slot_ok = (17'(in_point_slot) < MAXP);

  // ---------------------------------------------------------------------
  // Point store. Writes happen only while idle and reads only while a
  // search runs, so read and write never touch the store in the same
  // cycle; busy acts as the interlock.
  // ---------------------------------------------------------------------
  logic                         mem_we;
  logic [AW-1:0]                mem_waddr;
  logic [chss_pkg::ENTRY_W-1:0] mem_wdata;
  logic                         mem_re;
  logic [AW-1:0]                mem_raddr;
  logic [chss_pkg::ENTRY_W-1:0] mem_rdata;
  logic [chss_pkg::HASH_W-1:0]  rd_value;
  logic [chss_pkg::SRV_W-1:0]   rd_owner;

  assign mem_we    = accept & (in_req_type == chss_pkg::REQ_WRITE) & slot_ok;
  assign mem_waddr = AW'(in_point_slot);
  assign mem_wdata = {in_point_owner, in_point_hash};
  assign rd_value  = mem_rdata[chss_pkg::HASH_W-1:0];
  assign rd_owner  = mem_rdata[chss_pkg::ENTRY_W-1:chss_pkg::HASH_W];

  chss_ring_mem #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // ---------------------------------------------------------------------
  // Remainder unit for modulo mode
  // ---------------------------------------------------------------------
  logic                       div_start;
  logic                       div_done;
  logic [chss_pkg::SRV_W-1:0] div_rem;

  chss_divider u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (div_start),
    .dividend  (hash_eff),
    .divisor   (server_count_r),
    .done      (div_done),
    .remainder (div_rem)
  );

  // ---------------------------------------------------------------------
  // Binary search datapath: lo/hi bracket the first point not below h.
  // ---------------------------------------------------------------------
  logic [chss_pkg::HASH_W-1:0] h_r;
  logic [CW-1:0]               lo_r;
  logic [CW-1:0]               hi_r;
  logic [CW-1:0]               n_r;
  logic [CW-1:0]               mid_r;
  logic [CW-1:0]               mid;
  logic                        probing;
  logic [AW-1:0]               fin_addr;

  assign mid     = lo_r + ((hi_r - lo_r) >> 1);
  assign probing = (lo_r < hi_r);
  // Wrap to the first point when every point lies below the hash.
  assign fin_addr = (hi_r >= n_r) ? '0 : AW'(hi_r);

  always_ff @(posedge clk) begin
    if (lookup) begin
      h_r  <= hash_eff;
      lo_r <= '0;
      hi_r <= n_eff;
      n_r  <= n_eff;
    end else if (state_r == chss_pkg::ST_PROBE) begin
      mid_r <= mid;
    end else if (state_r == chss_pkg::ST_CMP) begin
      if (rd_value < h_r) begin
        lo_r <= mid_r + 1'b1;
      end else begin
        hi_r <= mid_r;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= chss_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      chss_pkg::ST_IDLE: begin
        if (lookup) begin
          if (mode_r == chss_pkg::MODE_RING) begin
            if (n_eff != '0) begin
              state_nxt = chss_pkg::ST_PROBE;
            end
          end else if (server_count_r != '0) begin
            state_nxt = chss_pkg::ST_DIV;
          end
        end
      end
      chss_pkg::ST_PROBE: begin
        state_nxt = probing ? chss_pkg::ST_CMP : chss_pkg::ST_FETCH;
      end
      chss_pkg::ST_CMP: begin
        state_nxt = chss_pkg::ST_PROBE;
      end
      chss_pkg::ST_FETCH: begin
        state_nxt = chss_pkg::ST_IDLE;
      end
      chss_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = chss_pkg::ST_IDLE;
        end
      end
      default: state_nxt = chss_pkg::ST_IDLE;
    endcase
  end

  // Result to load into the output register this cycle.
  logic                       res_load;
  logic [chss_pkg::SRV_W-1:0] res_srv;
  logic                       res_status;

  always_comb begin
    mem_re     = 1'b0;
    mem_raddr  = fin_addr;
    div_start  = 1'b0;
    res_load   = 1'b0;
    res_srv    = '0;
    res_status = chss_pkg::STAT_OK;
    unique case (state_r)
      chss_pkg::ST_IDLE: begin
        if (lookup) begin
          if (mode_r == chss_pkg::MODE_RING) begin
            // Empty ring: answer at once with the empty status.
            if (n_eff == '0) begin
              res_load   = 1'b1;
              res_status = chss_pkg::STAT_EMPTY;
            end
          end else if (server_count_r == '0) begin
            // No divisor: answer server 0 at once.
            res_load = 1'b1;
          end else begin
            div_start = 1'b1;
          end
        end
      end
      chss_pkg::ST_PROBE: begin
        mem_re    = 1'b1;
        mem_raddr = probing ? AW'(mid) : fin_addr;
      end
      chss_pkg::ST_CMP: ;
      chss_pkg::ST_FETCH: begin
        res_load = 1'b1;
        res_srv  = rd_owner;
      end
      chss_pkg::ST_DIV: begin
        if (div_done) begin
          res_load = 1'b1;
          res_srv  = div_rem;
        end
      end
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------
  // Result register: one-cycle strobe, receiver cannot stall.
  // ---------------------------------------------------------------------
  logic                       out_valid_r;
  logic [chss_pkg::SRV_W-1:0] out_server_index_r;
  logic                       out_status_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= res_load;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_server_index_r <= res_srv;
      out_status_r       <= res_status;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_server_index = out_server_index_r;
  assign out_status       = out_status_r;

endmodule

// File: hdl/chss_checker.sv
// Port-level checks for consistent_hash_server_select_core, bound to it.
// Watches the request and result handshakes only; no package dependency.
`timescale 1ns / 1ps

module chss_checker (
  input logic clk,
  input logic rst_n,
  input logic start,
  input logic busy,
  input logic in_req_type,
  input logic out_valid
);

  // A point write never produces a result.
  a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_req_type) |=> !out_valid)
    else $error("result strobed after a point write");

  // Busy only starts from an accepted lookup.
  a_busy_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start && in_req_type))
    else $error("busy raised without a lookup request");

  // Every busy period ends with exactly its result.
  a_busy_ends: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("lookup finished without a result");

  // A result comes from an immediate lookup or the end of a busy period.
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(start && !busy && in_req_type) || $fell(busy)))
    else $error("result strobed without a lookup");

endmodule

bind consistent_hash_server_select_core chss_checker u_chss_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .start       (start),
  .busy        (busy),
  .in_req_type (in_req_type),
  .out_valid   (out_valid)
);
